// ----- hdl/shared_buffer_multi_queue_assert.svh -----
// assertion macros shared by the checker files of the shared buffer queue block
`ifndef SHARED_BUFFER_MULTI_QUEUE_ASSERT_SVH
`define SHARED_BUFFER_MULTI_QUEUE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SBMQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define SBMQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/sbmq_pkg.sv -----
// shared types, constants and helpers for the shared buffer queue block
package sbmq_pkg;

	localparam int SLOTS      = 16;
	localparam int QUEUES     = 4;
	localparam int DATA_W     = 32;

	// slot index, pointer with room for the null value, queue index
	localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int PTR_W      = $clog2(SLOTS + 1);
	localparam int QIDX_W     = (QUEUES > 1) ? $clog2(QUEUES) : 1;

	localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(SLOTS);

	// operation codes
	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	// result status codes
	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_OVERFLOW  = 2'd1;
	localparam logic [1:0] STAT_UNDERFLOW = 2'd2;

	// access bundle from the controller to the slot store
	typedef struct packed {
		logic              rd_en;
		logic [SLOT_W-1:0] rd_addr;
		logic              val_we;
		logic [SLOT_W-1:0] val_addr;
		logic [DATA_W-1:0] val_data;
		logic              link_we;
		logic [SLOT_W-1:0] link_addr;
		logic [PTR_W-1:0]  link_data;
	} store_req_t;

	// a pointer at or beyond the slot count means null
	function automatic logic is_null(input logic [PTR_W-1:0] ptr);
		return ptr >= NULL_PTR;
	endfunction

endpackage

// ----- hdl/sbmq_store.sv -----
// slot store: value memory and link memory with per-entry link valid bits
module sbmq_store (
	input  logic                        clk,
	input  logic                        arst_n,
	input  sbmq_pkg::store_req_t        req,
	output logic [sbmq_pkg::DATA_W-1:0] val_rd,
	output logic [sbmq_pkg::PTR_W-1:0]  link_rd
);

	logic [sbmq_pkg::DATA_W-1:0] val_mem [sbmq_pkg::SLOTS];
	logic [sbmq_pkg::PTR_W-1:0]  link_mem [sbmq_pkg::SLOTS];
	logic [sbmq_pkg::SLOTS-1:0]  link_vld_q;

	logic [sbmq_pkg::DATA_W-1:0] val_rd_q;
	logic [sbmq_pkg::PTR_W-1:0]  link_rd_q;
	logic                        link_hit_q;
	logic [sbmq_pkg::SLOT_W-1:0] rd_addr_q;

	// value memory, one write and one registered read
	always_ff @(posedge clk) begin
		if (req.val_we)
			val_mem[req.val_addr] <= req.val_data;
		if (req.rd_en)
			val_rd_q <= val_mem[req.rd_addr];
	end

	// link memory, one write and one registered read
	always_ff @(posedge clk) begin
		if (req.link_we)
			link_mem[req.link_addr] <= req.link_data;
		if (req.rd_en) begin
			link_rd_q  <= link_mem[req.rd_addr];
			link_hit_q <= link_vld_q[req.rd_addr];
			rd_addr_q  <= req.rd_addr;
		end
	end

	// link valid bits: an unwritten entry reads as its reset chain value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_vld_q <= '0;
		end else if (req.link_we) begin
			link_vld_q[req.link_addr] <= 1'b1;
		end
	end

	assign val_rd  = val_rd_q;
	assign link_rd = link_hit_q ? link_rd_q
		: sbmq_pkg::PTR_W'(rd_addr_q) + sbmq_pkg::PTR_W'(1);

endmodule

// ----- hdl/shared_buffer_multi_queue.sv -----
// Several FIFO queues linked through one shared slot store with a free list.
// Pop, overflow and underflow results are registered from the EXEC state, a
// push result from the LINK state after EXEC, set by the registered read of
// the slot store and its single link write port (a push into a non-empty
// queue writes two links). One item at a time: s_tready stays low until then.
// Reset clears queue heads, free head and link valid bits at once; no sweep.
module shared_buffer_multi_queue (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] push_value
	input  logic [2:0]  s_tuser,   // [0] op, [2:1] queue_sel
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] pop_value
	output logic [2:0]  m_tuser    // [1:0] status, [2] store_full
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_EXEC = 3'b010,
		ST_LINK = 3'b100
	} state_t;

	state_t state_q, state_d;

	logic [sbmq_pkg::PTR_W-1:0]  head_q [sbmq_pkg::QUEUES];
	logic [sbmq_pkg::SLOT_W-1:0] tail_q [sbmq_pkg::QUEUES];
	logic [sbmq_pkg::PTR_W-1:0]  free_head_q;

	// item held while it is worked on
	logic                        op_q;
	logic [sbmq_pkg::QIDX_W-1:0] qsel_q;
	logic [sbmq_pkg::DATA_W-1:0] data_q;
	logic [sbmq_pkg::SLOT_W-1:0] slot_q;
	logic                        err_q;

	// output register
	logic        out_vld_q;
	logic [31:0] out_val_q;
	logic [1:0]  out_stat_q;
	logic        out_full_q;

	logic                        s_acc;
	logic                        in_op;
	logic [sbmq_pkg::QIDX_W-1:0] in_qsel;
	logic [sbmq_pkg::PTR_W-1:0]  rd_ptr;
	logic                        out_free;
	logic                        do_pop;
	logic                        do_push;
	logic                        do_err;
	logic                        do_link;
	logic                        emit;
	logic [31:0]                 emit_val;
	logic [1:0]                  emit_stat;
	logic                        emit_full;

	sbmq_pkg::store_req_t        req;
	logic [sbmq_pkg::DATA_W-1:0] val_rd;
	logic [sbmq_pkg::PTR_W-1:0]  link_rd;

	sbmq_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.val_rd  (val_rd),
		.link_rd (link_rd)
	);

	// input decode: the pointer to read is the queue head or the free head
	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign in_op    = s_tuser[0];
	assign in_qsel  = sbmq_pkg::QIDX_W'(32'(s_tuser[2:1]) % sbmq_pkg::QUEUES);
	assign rd_ptr   = (in_op == sbmq_pkg::OP_POP) ? head_q[in_qsel] : free_head_q;

	// step decode
	assign out_free = !out_vld_q || m_tready;
	assign do_err   = (state_q == ST_EXEC) && err_q && out_free;
	assign do_pop   = (state_q == ST_EXEC) && !err_q && (op_q == sbmq_pkg::OP_POP) && out_free;
	assign do_push  = (state_q == ST_EXEC) && !err_q && (op_q == sbmq_pkg::OP_PUSH);
	assign do_link  = (state_q == ST_LINK) && out_free;
	assign emit     = do_err || do_pop || do_link;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_acc)
					state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (do_push)
					state_d = ST_LINK;
				else if (do_err || do_pop)
					state_d = ST_IDLE;
			end
			ST_LINK: begin
				if (do_link)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// store accesses
	always_comb begin
		req           = '0;
		req.rd_en     = s_acc;
		req.rd_addr   = rd_ptr[sbmq_pkg::SLOT_W-1:0];
		req.val_we    = do_push;
		req.val_addr  = slot_q;
		req.val_data  = data_q;
		priority if (do_pop) begin
			req.link_we   = 1'b1;
			req.link_addr = slot_q;
			req.link_data = free_head_q;
		end else if (do_push && !sbmq_pkg::is_null(head_q[qsel_q])) begin
			req.link_we   = 1'b1;
			req.link_addr = tail_q[qsel_q];
			req.link_data = sbmq_pkg::PTR_W'(slot_q);
		end else if (do_link) begin
			req.link_we   = 1'b1;
			req.link_addr = slot_q;
			req.link_data = sbmq_pkg::NULL_PTR;
		end else begin
			req.link_we   = 1'b0;
		end
	end

	// result fields
	always_comb begin
		emit_val  = '0;
		emit_stat = sbmq_pkg::STAT_OK;
		emit_full = sbmq_pkg::is_null(free_head_q);
		if (do_err) begin
			emit_stat = (op_q == sbmq_pkg::OP_POP) ? sbmq_pkg::STAT_UNDERFLOW
				: sbmq_pkg::STAT_OVERFLOW;
		end else if (do_pop) begin
			emit_val  = 32'(signed'(val_rd));
			emit_full = 1'b0;
		end
	end

	// control state and queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			free_head_q <= '0;
			out_vld_q   <= 1'b0;
			for (int i = 0; i < sbmq_pkg::QUEUES; i++)
				head_q[i] <= sbmq_pkg::NULL_PTR;
		end else begin
			state_q <= state_d;
			if (emit)
				out_vld_q <= 1'b1;
			else if (m_tready)
				out_vld_q <= 1'b0;
			if (do_pop) begin
				head_q[qsel_q] <= link_rd;
				free_head_q    <= sbmq_pkg::PTR_W'(slot_q);
			end else if (do_push) begin
				free_head_q <= link_rd;
				if (sbmq_pkg::is_null(head_q[qsel_q]))
					head_q[qsel_q] <= sbmq_pkg::PTR_W'(slot_q);
			end
		end
	end

	// tails, item capture and output payload
	always_ff @(posedge clk) begin
		if (do_push)
			tail_q[qsel_q] <= slot_q;
		if (s_acc) begin
			op_q   <= in_op;
			qsel_q <= in_qsel;
			data_q <= sbmq_pkg::DATA_W'(s_tdata);
			slot_q <= rd_ptr[sbmq_pkg::SLOT_W-1:0];
			err_q  <= sbmq_pkg::is_null(rd_ptr);
		end
		if (emit) begin
			out_val_q  <= emit_val;
			out_stat_q <= emit_stat;
			out_full_q <= emit_full;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_val_q;
	assign m_tuser  = {out_full_q, out_stat_q};

endmodule

// ----- hdl/sbmq_checker.sv -----
// port-level checker for the shared buffer queue block, bound to the top level
`include "shared_buffer_multi_queue_assert.svh"

module sbmq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [2:0]  m_tuser
);

	// a held result beat stays offered
	`SBMQ_ASSERT_NXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid, "result beat dropped while stalled")

	// one item at a time: no input beat right after an accepted one
	`SBMQ_ASSERT_NXT(a_one_item, clk, arst_n, s_tvalid && s_tready, !s_tready, "input taken while busy")

	// failed operations carry a zero value
	`SBMQ_ASSERT_IMP(a_err_zero, clk, arst_n, m_tvalid && (m_tuser[1:0] != sbmq_pkg::STAT_OK), m_tdata == 32'd0, "failed operation with nonzero value")

	// an overflow can only happen on a full store
	`SBMQ_ASSERT_IMP(a_ovf_full, clk, arst_n, m_tvalid && (m_tuser[1:0] == sbmq_pkg::STAT_OVERFLOW), m_tuser[2], "overflow reported with free slots")

	// no unused status code
	`SBMQ_ASSERT_IMP(a_stat_code, clk, arst_n, m_tvalid, (m_tuser[1:0] == sbmq_pkg::STAT_OK) || (m_tuser[1:0] == sbmq_pkg::STAT_OVERFLOW) || (m_tuser[1:0] == sbmq_pkg::STAT_UNDERFLOW), "unknown status code")

endmodule

bind shared_buffer_multi_queue sbmq_checker u_sbmq_checker (.*);

// ----- tb/shared_buffer_multi_queue_test.sv -----
// testbench for the shared buffer multi queue block: random and directed push/pop traffic
module shared_buffer_multi_queue_test;

	localparam int STALL_LIMIT = 2000;
	localparam int GAP_MAX     = 20;
	localparam int HOLD_CYCLES = 300;

	// expected result of one queue operation
	typedef struct packed {
		logic [31:0] pop_value;
		logic [1:0]  status;
		logic        store_full;
	} queue_result_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = '0;   // [31:0] push_value
	logic [2:0]  s_tuser  = '0;   // [0] op, [2:1] queue_sel
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;         // [31:0] pop_value
	logic [2:0]  m_tuser;         // [1:0] status, [2] store_full

	// shadow copy of the linked slot store
	logic [sbmq_pkg::DATA_W-1:0] slot_data [sbmq_pkg::SLOTS];
	logic [sbmq_pkg::PTR_W-1:0]  slot_next [sbmq_pkg::SLOTS];
	logic [sbmq_pkg::PTR_W-1:0]  head_ptr  [sbmq_pkg::QUEUES];
	logic [sbmq_pkg::PTR_W-1:0]  tail_ptr  [sbmq_pkg::QUEUES];
	logic [sbmq_pkg::PTR_W-1:0]  free_ptr;

	queue_result_t expected_results [$];

	int  send_idle_pct  = 0;
	int  recv_stall_pct = 0;
	int  hold_left      = 0;
	int  idle_cycles    = 0;
	int  error_count    = 0;
	int  beats_sent     = 0;
	int  results_seen   = 0;
	int  push_count     = 0;
	int  pop_count      = 0;
	int  overflow_count = 0;
	int  underflow_count = 0;
	int  full_count     = 0;
	bit  valid_held     = 1'b0;

	shared_buffer_multi_queue u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// empty queues, every slot chained on the free list
	function automatic void clear_shadow_store();
		for (int i = 0; i < sbmq_pkg::SLOTS; i++) begin
			slot_data[i] = '0;
			slot_next[i] = sbmq_pkg::PTR_W'(i + 1);
		end
		for (int i = 0; i < sbmq_pkg::QUEUES; i++) begin
			head_ptr[i] = sbmq_pkg::NULL_PTR;
			tail_ptr[i] = '0;
		end
		free_ptr = '0;
	endfunction

	// apply one push or pop to the shadow store and return its result
	function automatic queue_result_t predict_queue_op(input logic op, input logic [1:0] sel,
			input logic [31:0] value);
		queue_result_t              res;
		logic [sbmq_pkg::PTR_W-1:0] slot;
		int                         q;
		res = '0;
		q = int'(sel) % sbmq_pkg::QUEUES;
		if (op == sbmq_pkg::OP_PUSH) begin
			if (free_ptr >= sbmq_pkg::NULL_PTR) begin
				res.status = sbmq_pkg::STAT_OVERFLOW;
			end else begin
				slot = free_ptr;
				free_ptr = slot_next[slot[sbmq_pkg::SLOT_W-1:0]];
				slot_data[slot[sbmq_pkg::SLOT_W-1:0]] = value[sbmq_pkg::DATA_W-1:0];
				slot_next[slot[sbmq_pkg::SLOT_W-1:0]] = sbmq_pkg::NULL_PTR;
				if (head_ptr[q] >= sbmq_pkg::NULL_PTR)
					head_ptr[q] = slot;
				else
					slot_next[tail_ptr[q][sbmq_pkg::SLOT_W-1:0]] = slot;
				tail_ptr[q] = slot;
			end
		end else begin
			slot = head_ptr[q];
			if (slot >= sbmq_pkg::NULL_PTR) begin
				res.status = sbmq_pkg::STAT_UNDERFLOW;
			end else begin
				res.pop_value = 32'(signed'(slot_data[slot[sbmq_pkg::SLOT_W-1:0]]));
				head_ptr[q] = slot_next[slot[sbmq_pkg::SLOT_W-1:0]];
				slot_next[slot[sbmq_pkg::SLOT_W-1:0]] = free_ptr;
				free_ptr = slot;
			end
		end
		res.store_full = (free_ptr >= sbmq_pkg::NULL_PTR);
		return res;
	endfunction

	function automatic logic [31:0] extreme_value(input int k);
		case (k % 8)
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			4: return 32'h0000_0001;
			5: return 32'haaaa_aaaa;
			6: return 32'h5555_5555;
			default: return 32'h8000_0001;
		endcase
	endfunction

	function automatic logic [31:0] random_value();
		if ($urandom_range(7) == 0)
			return extreme_value($urandom_range(7));
		return $urandom;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (error_count < 30)
			$display("mismatch at result %0d: %s got %h expected %h", results_seen, what, got,
				want);
		error_count++;
	endtask

	// offer one beat, wait for the handshake, record its prediction, then maybe idle
	task automatic send_beat(input logic op, input logic [1:0] sel, input logic [31:0] value);
		queue_result_t res;
		int            gap;
		gap = 0;
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		s_tuser  <= {sel, op};
		do @(posedge clk); while (!s_tready);
		res = predict_queue_op(op, sel, value);
		expected_results.push_back(res);
		beats_sent++;
		if (op == sbmq_pkg::OP_PUSH) push_count++; else pop_count++;
		if (res.status == sbmq_pkg::STAT_OVERFLOW) overflow_count++;
		if (res.status == sbmq_pkg::STAT_UNDERFLOW) underflow_count++;
		if (res.store_full) full_count++;
		while (gap < GAP_MAX && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			valid_held = 1'b0;
			repeat (gap) @(posedge clk);
		end else begin
			valid_held = 1'b1;
		end
	endtask

	// drop valid and wait until every expected result has come back
	task automatic wait_all_results();
		if (valid_held) begin
			s_tvalid <= 1'b0;
			valid_held = 1'b0;
		end
		do @(posedge clk); while (expected_results.size() != 0);
	endtask

	// receiver: long hold-off when asked, otherwise random stalls
	always @(posedge clk) begin
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// compare each result beat with the oldest prediction
	always @(posedge clk) begin
		queue_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected beat, tdata", m_tdata, '0);
			end else begin
				want = expected_results.pop_front();
				if (m_tdata !== want.pop_value)
					report_mismatch("pop_value", m_tdata, want.pop_value);
				if (m_tuser[1:0] !== want.status)
					report_mismatch("status", 32'(m_tuser[1:0]), 32'(want.status));
				if (m_tuser[2] !== want.store_full)
					report_mismatch("store_full", 32'(m_tuser[2]), 32'(want.store_full));
			end
			results_seen++;
		end
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("timeout: no beat for %0d cycles, %0d results outstanding",
					idle_cycles, expected_results.size());
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// pops on empty queues right after reset
	task automatic test_underflow_on_empty();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		send_beat(sbmq_pkg::OP_POP, 2'd0, 32'hffff_ffff);
		send_beat(sbmq_pkg::OP_POP, 2'd3, 32'h0000_0000);
		send_beat(sbmq_pkg::OP_POP, 2'd1, 32'h8000_0000);
		wait_all_results();
	endtask

	// fill every slot, then push into a full store
	task automatic test_fill_and_overflow();
		for (int i = 0; i < sbmq_pkg::SLOTS; i++)
			send_beat(sbmq_pkg::OP_PUSH, 2'(i), extreme_value(i));
		send_beat(sbmq_pkg::OP_PUSH, 2'd0, 32'h1234_5678);
		send_beat(sbmq_pkg::OP_PUSH, 2'd3, 32'hffff_ffff);
		wait_all_results();
	endtask

	// heads of each queue come back in push order
	task automatic test_fifo_order();
		for (int i = 0; i < sbmq_pkg::QUEUES; i++)
			send_beat(sbmq_pkg::OP_POP, 2'(i), 32'h7fff_ffff);
		wait_all_results();
	endtask

	// random bursts, each biased toward pushes or pops and sometimes on one queue
	task automatic test_random_mix(input int count, input int send_pct, input int stall_pct);
		int         push_pct;
		int         fixed_q;
		logic [1:0] sel;
		send_idle_pct = send_pct;
		recv_stall_pct = stall_pct;
		push_pct = 50;
		fixed_q = -1;
		for (int i = 0; i < count; i++) begin
			if (i % 24 == 0) begin
				case ($urandom_range(2))
					0: push_pct = 15;
					1: push_pct = 50;
					default: push_pct = 85;
				endcase
				fixed_q = $urandom_range(1) ? int'($urandom_range(sbmq_pkg::QUEUES - 1)) : -1;
			end
			sel = (fixed_q < 0) ? 2'($urandom_range(3)) : 2'(fixed_q);
			send_beat(($urandom_range(99) < push_pct) ? sbmq_pkg::OP_PUSH : sbmq_pkg::OP_POP,
				sel, random_value());
		end
		wait_all_results();
	endtask

	// receiver holds off while the sender keeps offering, so the input stalls
	task automatic test_backpressure_fill();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_left = HOLD_CYCLES;
		for (int i = 0; i < 40; i++)
			send_beat(($urandom_range(3) == 0) ? sbmq_pkg::OP_POP : sbmq_pkg::OP_PUSH,
				2'($urandom_range(3)), random_value());
		wait_all_results();
	endtask

	// sender pauses mid-stream until all results are back, then resumes
	task automatic test_pause_until_drained();
		send_idle_pct = 10;
		recv_stall_pct = 20;
		for (int i = 0; i < 30; i++)
			send_beat(1'($urandom_range(1)), 2'($urandom_range(3)), random_value());
		wait_all_results();
		for (int i = 0; i < 30; i++)
			send_beat(1'($urandom_range(1)), 2'($urandom_range(3)), random_value());
		wait_all_results();
	endtask

	initial begin
		clear_shadow_store();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_underflow_on_empty();
		test_fill_and_overflow();
		test_fifo_order();
		test_random_mix(280, 0, 0);
		test_random_mix(280, 45, 0);
		test_random_mix(280, 0, 45);
		test_random_mix(280, 36, 36);
		test_backpressure_fill();
		test_pause_until_drained();
		wait_all_results();
		repeat (10) @(posedge clk);
		if (expected_results.size() != 0)
			report_mismatch("results left over", 32'(expected_results.size()), '0);
		$display("covered %0d beats: %0d pushes, %0d pops, %0d results checked", beats_sent,
			push_count, pop_count, results_seen);
		$display("overflows %0d, underflows %0d, results with store full %0d, mismatches %0d",
			overflow_count, underflow_count, full_count, error_count);
		if (error_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
